### rtl/bbc_pkg.sv
// Shared types, constants and digit adjust functions for the binary/BCD converter.
package bbc_pkg;

    localparam int OPERAND_W = 128;
    localparam int LANE_W    = 64;
    localparam int SS_W      = 32;

    localparam logic MODE_TO_BCD = 1'b0;
    localparam logic MODE_TO_BIN = 1'b1;

    localparam logic [3:0] UP_LIMIT   = 4'd4;
    localparam logic [3:0] DOWN_LIMIT = 4'd8;
    localparam logic [3:0] ADJ        = 4'd3;

    typedef struct packed {
        logic valid;
        logic mode;
    } t_ctl;

    // double dabble correction, kept to one nibble
    function automatic logic [3:0] dabble_up(input logic [3:0] d);
        logic [3:0] r;
        r = (d > UP_LIMIT) ? 4'(d + ADJ) : d;
        return r;
    endfunction

    // reverse dabble correction, kept to one nibble
    function automatic logic [3:0] dabble_down(input logic [3:0] d);
        logic [3:0] r;
        r = (d >= DOWN_LIMIT) ? 4'(d - ADJ) : d;
        return r;
    endfunction

endpackage

### rtl/bbc_stage.sv
// One shift-and-adjust step of the conversion pipeline, with its stage registers.
module bbc_stage #(
    parameter int BINARY_BITS = 96,
    parameter int BCD_DIGITS  = 32,
    parameter int STEP_IDX    = 0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_advance,
    input  bbc_pkg::t_ctl            i_ctl,
    input  logic [BINARY_BITS-1:0]   i_bin,
    input  logic [4*BCD_DIGITS-1:0]  i_bcd,
    input  logic [bbc_pkg::SS_W-1:0] i_sign_scale,
    output bbc_pkg::t_ctl            o_ctl,
    output logic [BINARY_BITS-1:0]   o_bin,
    output logic [4*BCD_DIGITS-1:0]  o_bcd,
    output logic [bbc_pkg::SS_W-1:0] o_sign_scale
);

    localparam int BCD_W = 4 * BCD_DIGITS;
    localparam bit LAST  = (STEP_IDX == BINARY_BITS - 1);

    bbc_pkg::t_ctl            r_ctl;
    logic [BINARY_BITS-1:0]   r_bin, n_bin;
    logic [BCD_W-1:0]         r_bcd, n_bcd;
    logic [bbc_pkg::SS_W-1:0] r_ss;
    logic [BCD_W-1:0]         sh_bcd;

    always_comb begin
        unique case (i_ctl.mode)
            bbc_pkg::MODE_TO_BCD: begin
                sh_bcd = {i_bcd[BCD_W-2:0], i_bin[BINARY_BITS-1]};
                n_bin  = {i_bin[BINARY_BITS-2:0], 1'b0};
            end
            bbc_pkg::MODE_TO_BIN: begin
                sh_bcd = {1'b0, i_bcd[BCD_W-1:1]};
                n_bin  = {i_bcd[0], i_bin[BINARY_BITS-1:1]};
            end
            default: begin
                sh_bcd = i_bcd;
                n_bin  = i_bin;
            end
        endcase
    end

    // per-digit correction after the shift; the final forward step takes none
    always_comb begin
        n_bcd = sh_bcd;
        for (int d = 0; d < BCD_DIGITS; d++) begin
            if (i_ctl.mode == bbc_pkg::MODE_TO_BIN) begin
                n_bcd[4*d +: 4] = bbc_pkg::dabble_down(sh_bcd[4*d +: 4]);
            end else if (!LAST) begin
                n_bcd[4*d +: 4] = bbc_pkg::dabble_up(sh_bcd[4*d +: 4]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_advance) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_bin <= n_bin;
            r_bcd <= n_bcd;
            r_ss  <= i_sign_scale;
        end
    end

    assign o_ctl        = r_ctl;
    assign o_bin        = r_bin;
    assign o_bcd        = r_bcd;
    assign o_sign_scale = r_ss;

endmodule

### rtl/binary_bcd_converter_96.sv
// Top level: pipelined binary to BCD and BCD to binary converter.
//
// Input channel: i_valid with i_mode, i_operand_low, i_operand_high and
// i_sign_scale_in; a word is taken at a clock edge with i_valid high and
// o_stall low. Mode 0 turns a BINARY_BITS-bit binary value into packed BCD,
// mode 1 turns packed BCD of BCD_DIGITS digits into binary (wrapping modulo
// 2^BINARY_BITS). The sign/scale word rides along unchanged.
// Output channel: o_valid with o_result_low, o_result_high, o_sign_scale_out;
// a word leaves at an edge with o_valid high and i_stall low.
// Pipeline: one stage per shift-and-adjust step; the last stage register
// drives the outputs.
// Throughput: one word per cycle while the receiver takes results.
// Stall: when the output word is held by i_stall, the whole pipeline freezes
// and o_stall is raised; nothing is dropped or repeated, and bubbles move
// forward freely whenever the output stage is empty.
// Reset: synchronous, active low; clears all stage valid bits, so the
// pipeline comes up empty and accepts a word on the next cycle.
module binary_bcd_converter_96 #(
    parameter int BINARY_BITS = 96,
    parameter int BCD_DIGITS  = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_mode,
    input  logic [bbc_pkg::LANE_W-1:0] i_operand_low,
    input  logic [bbc_pkg::LANE_W-1:0] i_operand_high,
    input  logic [bbc_pkg::SS_W-1:0]   i_sign_scale_in,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [bbc_pkg::LANE_W-1:0] o_result_low,
    output logic [bbc_pkg::LANE_W-1:0] o_result_high,
    output logic [bbc_pkg::SS_W-1:0]   o_sign_scale_out
);

    localparam int BCD_W = 4 * BCD_DIGITS;

    bbc_pkg::t_ctl            ctl [0:BINARY_BITS];
    logic [BINARY_BITS-1:0]   bin [0:BINARY_BITS];
    logic [BCD_W-1:0]         bcd [0:BINARY_BITS];
    logic [bbc_pkg::SS_W-1:0] ss  [0:BINARY_BITS];

    logic                          advance;
    logic [bbc_pkg::OPERAND_W-1:0] operand;
    logic [bbc_pkg::OPERAND_W-1:0] result;

    // freeze everything while the output word is held
    assign advance = !(o_valid && i_stall);
    assign o_stall = !advance;

    assign operand = {i_operand_high, i_operand_low};

    assign ctl[0] = '{valid: i_valid, mode: i_mode};
    assign ss[0]  = i_sign_scale_in;
    assign bin[0] = (i_mode == bbc_pkg::MODE_TO_BCD) ? operand[BINARY_BITS-1:0]
                                                     : {BINARY_BITS{1'b0}};
    assign bcd[0] = (i_mode == bbc_pkg::MODE_TO_BIN) ? operand[BCD_W-1:0]
                                                     : {BCD_W{1'b0}};

    for (genvar k = 0; k < BINARY_BITS; k++) begin : g_step
        bbc_stage #(
            .BINARY_BITS (BINARY_BITS),
            .BCD_DIGITS  (BCD_DIGITS),
            .STEP_IDX    (k)
        ) u_stage (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_advance    (advance),
            .i_ctl        (ctl[k]),
            .i_bin        (bin[k]),
            .i_bcd        (bcd[k]),
            .i_sign_scale (ss[k]),
            .o_ctl        (ctl[k+1]),
            .o_bin        (bin[k+1]),
            .o_bcd        (bcd[k+1]),
            .o_sign_scale (ss[k+1])
        );
    end

    always_comb begin
        unique case (ctl[BINARY_BITS].mode)
            bbc_pkg::MODE_TO_BCD: result = bbc_pkg::OPERAND_W'(bcd[BINARY_BITS]);
            bbc_pkg::MODE_TO_BIN: result = bbc_pkg::OPERAND_W'(bin[BINARY_BITS]);
            default:              result = '0;
        endcase
    end

    assign o_valid          = ctl[BINARY_BITS].valid;
    assign o_result_low     = result[bbc_pkg::LANE_W-1:0];
    assign o_result_high    = result[bbc_pkg::OPERAND_W-1:bbc_pkg::LANE_W];
    assign o_sign_scale_out = ss[BINARY_BITS];

    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with an empty output stage");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> ctl[1].valid)
        else $error("accepted word missing from the first stage");

    a_freeze_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(ctl[1]) && $stable(ss[1]))
        else $error("first stage moved during a stall");

    a_bin_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ctl[BINARY_BITS].mode == bbc_pkg::MODE_TO_BIN)
            |-> (result >> BINARY_BITS) == '0)
        else $error("binary result wider than the mantissa");

endmodule
